### hw/rtl/srep_pkg.sv
// srep_pkg: shared widths, register indexes, window control struct and the
// register-to-unit unpacking function of the substring replace-all block.
// No dependencies.
package srep_pkg;

    localparam int UNIT_W          = 16;
    localparam int LEN_W           = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int DEF_MAX_SEARCH  = 8;
    localparam int DEF_MAX_REPLACE = 8;
    localparam int UNITS_PER_REG   = CFG_DATA_W / UNIT_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_LOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_HIGH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_HIGH   = 3'd5;

    // Strobes from the sequencer to the window row
    typedef struct packed {
        logic latch;   // copy pattern units into the cells
        logic load;    // write the new unit into the selected cell
        logic shift;   // every cell takes its right neighbor's unit
    } t_win_ctrl;

    // Unit i of a low/high register pair; units past the registers read as 0.
    function automatic logic [UNIT_W-1:0] reg_unit(input logic [CFG_DATA_W-1:0] lo,
                                                   input logic [CFG_DATA_W-1:0] hi,
                                                   input int i);
        logic [UNIT_W-1:0] u;
        u = '0;
        if (i < UNITS_PER_REG) begin
            u = lo[UNIT_W*i +: UNIT_W];
        end else if (i < 2*UNITS_PER_REG) begin
            u = hi[UNIT_W*(i-UNITS_PER_REG) +: UNIT_W];
        end
        return u;
    endfunction

endpackage

### hw/rtl/substring_replace_all_top.sv
// substring_replace_all_top: streaming replace-all of a configured pattern.
// Uses srep_pkg and srep_window (row of srep_cell).
//
// Takes a string as 16-bit code units and returns it with every leftmost,
// non-overlapping occurrence of the search pattern replaced by the
// replacement text. Units that may still begin a match sit in a row of
// cells; the sequencer appends each unit at the end of the row, compares
// the whole row against the pattern at once and shifts the oldest unit
// out while the row is no prefix of the pattern. Pattern and replacement
// (lengths clamp at MAX_SEARCH / MAX_REPLACE) are copied from the registers
// when the first transaction of a string arrives, so register writes made
// during a string take effect with the next one. An empty pattern puts the
// replacement before the first unit and after every unit. The result on
// the end-of-string transaction carries tlast; if nothing is left to emit a
// single closing result with tuser 0 is given. One item is in work at a
// time: a unit passes through accept, dispatch, append, compare and flush
// check, each of its results going through the single output register,
// and an end-of-string item adds a close step. Every result step waits
// while the output register is stalled. A transaction with neither a
// unit nor an end mark is taken and dropped.
module substring_replace_all_top
    import srep_pkg::*;
#(
    parameter int MAX_SEARCH  = DEF_MAX_SEARCH,
    parameter int MAX_REPLACE = DEF_MAX_REPLACE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input string
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [UNIT_W-1:0]     s_axis_tdata,   // [15:0] code_unit
    input  logic                  s_axis_tuser,   // [0] unit_present
    input  logic                  s_axis_tlast,   // end_of_string
    // rewritten string
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [UNIT_W-1:0]     m_axis_tdata,   // [15:0] out_unit
    output logic                  m_axis_tuser,   // [0] out_valid
    output logic                  m_axis_tlast,   // out_last
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW   = $clog2(MAX_SEARCH+1);
    localparam int IW   = $clog2(MAX_SEARCH);
    localparam int RL_W = $clog2(MAX_REPLACE+1);
    localparam int RI_W = (MAX_REPLACE > 1) ? $clog2(MAX_REPLACE) : 1;

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;  // waiting for a transaction
    localparam logic [2:0] ST_PRE    = 3'd1;  // leading replacement, empty pattern
    localparam logic [2:0] ST_UNIT_E = 3'd2;  // pass unit through, empty pattern
    localparam logic [2:0] ST_APPEND = 3'd3;  // append unit to window
    localparam logic [2:0] ST_SCAN   = 3'd4;  // compare, shift out mismatches
    localparam logic [2:0] ST_REP    = 3'd5;  // emit replacement
    localparam logic [2:0] ST_FLUSH  = 3'd6;  // end of string: drain window, else back to idle
    localparam logic [2:0] ST_CLOSE  = 3'd7;  // end of string: empty close

    // Configuration registers
    logic [LEN_W-1:0]      r_search_length;
    logic [CFG_DATA_W-1:0] r_search_low;
    logic [CFG_DATA_W-1:0] r_search_high;
    logic [LEN_W-1:0]      r_replace_length;
    logic [CFG_DATA_W-1:0] r_replace_low;
    logic [CFG_DATA_W-1:0] r_replace_high;

    // Sequencer state
    logic [2:0]        r_state, n_state;
    logic              r_started, n_started;
    logic              r_first;
    logic              r_emitted, n_emitted;
    logic [CW-1:0]     r_count, n_count;
    logic [RL_W-1:0]   r_rep_idx, n_rep_idx;

    // Current item and latched pattern/replacement
    logic [UNIT_W-1:0] r_unit;
    logic              r_present;
    logic              r_end;
    logic [CW-1:0]     r_pat_len;
    logic [RL_W-1:0]   r_rep_len;
    logic [UNIT_W-1:0] r_rep [MAX_REPLACE];

    // Output register
    logic              r_out_valid;
    logic [UNIT_W-1:0] r_out_unit;
    logic              r_out_flag;
    logic              r_out_last;

    logic              w_accept;
    logic              w_go;
    logic              w_emit;
    logic [UNIT_W-1:0] w_emit_unit;
    logic              w_emit_flag;
    logic              w_emit_last;
    logic              w_rep_more;
    logic              w_rep_last;
    logic [UNIT_W-1:0] w_rep_unit;
    logic [IW-1:0]     w_load_idx;
    t_win_ctrl         w_ctrl;
    logic [UNIT_W-1:0] w_head;
    logic              w_prefix;
    logic [CW-1:0]     w_pat_len_cfg;
    logic [RL_W-1:0]   w_rep_len_cfg;

    //------------------------------------------------------------------
    // Configuration port
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_length  <= '0;
            r_search_low     <= '0;
            r_search_high    <= '0;
            r_replace_length <= '0;
            r_replace_low    <= '0;
            r_replace_high   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SEARCH_LENGTH:  r_search_length  <= i_cfg_data[LEN_W-1:0];
                REG_SEARCH_LOW:     r_search_low     <= i_cfg_data;
                REG_SEARCH_HIGH:    r_search_high    <= i_cfg_data;
                REG_REPLACE_LENGTH: r_replace_length <= i_cfg_data[LEN_W-1:0];
                REG_REPLACE_LOW:    r_replace_low    <= i_cfg_data;
                REG_REPLACE_HIGH:   r_replace_high   <= i_cfg_data;
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    // Clamped lengths as latched at string start
    assign w_pat_len_cfg = (int'(r_search_length) > MAX_SEARCH) ?
                           CW'(MAX_SEARCH) : CW'(r_search_length);
    assign w_rep_len_cfg = (int'(r_replace_length) > MAX_REPLACE) ?
                           RL_W'(MAX_REPLACE) : RL_W'(r_replace_length);

    //------------------------------------------------------------------
    // Handshakes and helpers
    //------------------------------------------------------------------
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && (r_state == ST_IDLE);
    // output register free this cycle (empty or being drained)
    assign w_go          = !r_out_valid || m_axis_tready;

    assign w_rep_more = (r_rep_idx < r_rep_len);
    assign w_rep_last = (RL_W'(r_rep_idx + RL_W'(1)) == r_rep_len);
    assign w_rep_unit = r_rep[r_rep_idx[RI_W-1:0]];

    // window never really fills; clamp keeps the write slot in range
    assign w_load_idx = (r_count >= CW'(MAX_SEARCH)) ?
                        IW'(MAX_SEARCH-1) : r_count[IW-1:0];

    //------------------------------------------------------------------
    // Sequencer: one step per cycle, emitting steps wait on w_go
    //------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_started   = r_started;
        n_emitted   = r_emitted;
        n_count     = r_count;
        n_rep_idx   = r_rep_idx;
        w_emit      = 1'b0;
        w_emit_unit = w_head;
        w_emit_flag = 1'b1;
        w_emit_last = 1'b0;
        w_ctrl      = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (s_axis_tuser || s_axis_tlast)) begin
                    n_state   = ST_PRE;
                    n_rep_idx = '0;
                    n_emitted = 1'b0;
                    if (!r_started) begin
                        n_started   = 1'b1;
                        n_count     = '0;
                        w_ctrl.latch = 1'b1;
                    end
                end
            end
            ST_PRE: begin
                if (r_first && (r_pat_len == '0) && w_rep_more) begin
                    w_emit      = 1'b1;
                    w_emit_unit = w_rep_unit;
                    w_emit_last = r_end && !r_present && w_rep_last;
                    if (w_go) begin
                        n_rep_idx = RL_W'(r_rep_idx + RL_W'(1));
                    end
                end else begin
                    n_rep_idx = '0;
                    if (!r_present) begin
                        n_state = ST_FLUSH;
                    end else if (r_pat_len == '0) begin
                        n_state = ST_UNIT_E;
                    end else begin
                        n_state = ST_APPEND;
                    end
                end
            end
            ST_UNIT_E: begin
                w_emit      = 1'b1;
                w_emit_unit = r_unit;
                w_emit_last = r_end && (r_rep_len == '0);
                if (w_go) begin
                    n_state = ST_REP;
                end
            end
            ST_APPEND: begin
                w_ctrl.load = 1'b1;
                n_count     = CW'(CW'(w_load_idx) + CW'(1));
                n_state     = ST_SCAN;
            end
            ST_SCAN: begin
                if (w_prefix) begin
                    if (r_count >= r_pat_len) begin
                        // full match: window is consumed by the replacement
                        n_count   = '0;
                        n_rep_idx = '0;
                        n_state   = ST_REP;
                    end else begin
                        n_state = ST_FLUSH;
                    end
                end else begin
                    w_emit      = 1'b1;
                    w_emit_last = r_end && (r_count == CW'(1));
                    if (w_go) begin
                        w_ctrl.shift = 1'b1;
                        n_count      = CW'(r_count - CW'(1));
                    end
                end
            end
            ST_REP: begin
                if (w_rep_more) begin
                    w_emit      = 1'b1;
                    w_emit_unit = w_rep_unit;
                    w_emit_last = r_end && w_rep_last;
                    if (w_go) begin
                        n_rep_idx = RL_W'(r_rep_idx + RL_W'(1));
                        if (w_rep_last) begin
                            n_state = ST_FLUSH;
                        end
                    end
                end else begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_end) begin
                    n_state = ST_IDLE;
                end else if (r_count != '0) begin
                    w_emit      = 1'b1;
                    w_emit_last = (r_count == CW'(1));
                    if (w_go) begin
                        w_ctrl.shift = 1'b1;
                        n_count      = CW'(r_count - CW'(1));
                    end
                end else begin
                    n_state = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                if (r_emitted) begin
                    n_started = 1'b0;
                    n_state   = ST_IDLE;
                end else begin
                    // nothing was emitted for this end-of-string transaction
                    w_emit      = 1'b1;
                    w_emit_unit = '0;
                    w_emit_flag = 1'b0;
                    w_emit_last = 1'b1;
                    if (w_go) begin
                        n_started = 1'b0;
                        n_state   = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_emit && w_go) begin
            n_emitted = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_started <= 1'b0;
            r_emitted <= 1'b0;
            r_count   <= '0;
            r_rep_idx <= '0;
            r_first   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_emitted <= n_emitted;
            r_count   <= n_count;
            r_rep_idx <= n_rep_idx;
            if (w_accept) begin
                r_first <= !r_started;
            end
        end
    end

    // Item capture and pattern/replacement latch (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_unit    <= s_axis_tdata;
            r_present <= s_axis_tuser;
            r_end     <= s_axis_tlast;
        end
        if (w_ctrl.latch) begin
            r_pat_len <= w_pat_len_cfg;
            r_rep_len <= w_rep_len_cfg;
            for (int i = 0; i < MAX_REPLACE; i++) begin
                r_rep[i] <= reg_unit(r_replace_low, r_replace_high, i);
            end
        end
    end

    //------------------------------------------------------------------
    // Match window
    //------------------------------------------------------------------
    srep_window #(
        .MAX_SEARCH (MAX_SEARCH)
    ) u_window (
        .i_clk         (i_clk),
        .i_ctrl        (w_ctrl),
        .i_load_idx    (w_load_idx),
        .i_load_unit   (r_unit),
        .i_count       (r_count),
        .i_search_low  (r_search_low),
        .i_search_high (r_search_high),
        .o_head        (w_head),
        .o_prefix      (w_prefix)
    );

    //------------------------------------------------------------------
    // Output register
    //------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit && w_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit && w_go) begin
            r_out_unit <= w_emit_unit;
            r_out_flag <= w_emit_flag;
            r_out_last <= w_emit_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_unit;
    assign m_axis_tuser  = r_out_flag;
    assign m_axis_tlast  = r_out_last;

endmodule

### hw/rtl/srep_cell.sv
// srep_cell: one window position. Holds one held unit and the pattern unit
// for its place, and extends the prefix-match chain. Uses srep_pkg.
module srep_cell
    import srep_pkg::*;
(
    input  logic              i_clk,
    input  t_win_ctrl         i_ctrl,
    input  logic              i_sel,
    input  logic [UNIT_W-1:0] i_load_unit,
    input  logic [UNIT_W-1:0] i_right_unit,
    input  logic [UNIT_W-1:0] i_pat,
    input  logic              i_active,
    input  logic              i_prefix,
    output logic [UNIT_W-1:0] o_unit,
    output logic              o_prefix
);

    logic [UNIT_W-1:0] r_unit;
    logic [UNIT_W-1:0] r_pat;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.latch) begin
            r_pat <= i_pat;
        end
        if (i_ctrl.load && i_sel) begin
            r_unit <= i_load_unit;
        end else if (i_ctrl.shift) begin
            r_unit <= i_right_unit;
        end
    end

    // empty slots do not break the prefix
    assign o_prefix = i_prefix & (~i_active | (r_unit == r_pat));
    assign o_unit   = r_unit;

endmodule

### hw/rtl/srep_window.sv
// srep_window: row of srep_cell instances forming the match window, with the
// left-shift path and the prefix-match chain. Uses srep_pkg, srep_cell.
module srep_window
    import srep_pkg::*;
#(
    parameter int MAX_SEARCH = DEF_MAX_SEARCH
) (
    input  logic                               i_clk,
    input  t_win_ctrl                          i_ctrl,
    input  logic [$clog2(MAX_SEARCH)-1:0]      i_load_idx,
    input  logic [UNIT_W-1:0]                  i_load_unit,
    input  logic [$clog2(MAX_SEARCH+1)-1:0]    i_count,
    input  logic [CFG_DATA_W-1:0]              i_search_low,
    input  logic [CFG_DATA_W-1:0]              i_search_high,
    output logic [UNIT_W-1:0]                  o_head,
    output logic                               o_prefix
);

    localparam int IW = $clog2(MAX_SEARCH);
    localparam int CW = $clog2(MAX_SEARCH+1);

    logic [UNIT_W-1:0] w_unit   [MAX_SEARCH+1];
    logic              w_prefix [MAX_SEARCH+1];

    assign w_unit[MAX_SEARCH] = '0;
    assign w_prefix[0]        = 1'b1;

    for (genvar g = 0; g < MAX_SEARCH; g++) begin : g_cell
        srep_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (i_ctrl),
            .i_sel        (i_load_idx == IW'(g)),
            .i_load_unit  (i_load_unit),
            .i_right_unit (w_unit[g+1]),
            .i_pat        (reg_unit(i_search_low, i_search_high, g)),
            .i_active     (i_count > CW'(g)),
            .i_prefix     (w_prefix[g]),
            .o_unit       (w_unit[g]),
            .o_prefix     (w_prefix[g+1])
        );
    end

    assign o_head   = w_unit[0];
    assign o_prefix = w_prefix[MAX_SEARCH];

endmodule
